[hw/rtl/frsm_pkg.sv]
`timescale 1ns / 1ps
// shared constants, codes and types of the flash record store manager
// no dependencies

package frsm_pkg;

   localparam logic [31:0] REC_MAGIC    = 32'hf1a548a2;
   localparam int          PAGE_BYTES   = (1 << 8);
   localparam int          HEADER_BYTES = 16;
   localparam logic [7:0]  MAX_PAYLOAD  = 8'(PAGE_BYTES - HEADER_BYTES);

   localparam logic [1:0] FUNC_SCAN  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_ERASE = 2'd3;

   localparam logic [3:0] KIND_SCAN_ACK   = 4'd0;
   localparam logic [3:0] KIND_READ_HIT   = 4'd1;
   localparam logic [3:0] KIND_READ_MISS  = 4'd2;
   localparam logic [3:0] KIND_ERASE_SEC  = 4'd3;
   localparam logic [3:0] KIND_PROGRAM    = 4'd4;
   localparam logic [3:0] KIND_BAD_SIZE   = 4'd5;
   localparam logic [3:0] KIND_NO_SPACE   = 4'd6;
   localparam logic [3:0] KIND_ERASED_ALL = 4'd7;
   localparam logic [3:0] KIND_TABLE_FULL = 4'd8;
   localparam logic [3:0] KIND_SCAN_END   = 4'd9;

   localparam logic REG_SECTORS = 1'b0;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } fifo_ctl_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  page;
      logic [31:0] sig;
      logic [7:0]  size;
      logic [31:0] gen;
      logic [3:0]  sector;
      logic        last;
   } res_type;

   function automatic res_type mk_res(logic [3:0] kind, logic [31:0] page,
                                      logic [31:0] sig, logic [7:0] size,
                                      logic [31:0] gen, logic [31:0] sector,
                                      logic last);
      res_type r;
      r.kind   = kind;
      r.page   = page[7:0];
      r.sig    = sig;
      r.size   = size;
      r.gen    = gen;
      r.sector = sector[3:0];
      r.last   = last;
      return r;
   endfunction

endpackage

[hw/rtl/frsm_cell.sv]
`timescale 1ns / 1ps
// one table slot of the rotating entry ring
// depends on nothing but its parameters

module frsm_cell #(
   parameter int PG_W  = 8,
   parameter int SEC_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             shift,
   input  logic             in_valid,
   input  logic [31:0]      in_sig,
   input  logic [PG_W-1:0]  in_page,
   input  logic [SEC_W-1:0] in_sec,
   input  logic [7:0]       in_size,
   input  logic [31:0]      in_gen,
   output logic             out_valid,
   output logic [31:0]      out_sig,
   output logic [PG_W-1:0]  out_page,
   output logic [SEC_W-1:0] out_sec,
   output logic [7:0]       out_size,
   output logic [31:0]      out_gen
);

   logic             valid_ff;
   logic [31:0]      sig_ff;
   logic [PG_W-1:0]  page_ff;
   logic [SEC_W-1:0] sec_ff;
   logic [7:0]       size_ff;
   logic [31:0]      gen_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         sig_ff  <= in_sig;
         page_ff <= in_page;
         sec_ff  <= in_sec;
         size_ff <= in_size;
         gen_ff  <= in_gen;
      end
   end

   assign out_valid = valid_ff;
   assign out_sig   = sig_ff;
   assign out_page  = page_ff;
   assign out_sec   = sec_ff;
   assign out_size  = size_ff;
   assign out_gen   = gen_ff;

endmodule

[hw/rtl/frsm_fifo.sv]
`timescale 1ns / 1ps
// free page queue: circular memory of page numbers with their sectors
// depends on frsm_pkg

module frsm_fifo
   import frsm_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int PG_W  = 8,
   parameter int SEC_W = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fifo_ctl_type               ctl,
   input  logic [PG_W-1:0]            push_page,
   input  logic [SEC_W-1:0]           push_sec,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic [PG_W-1:0]            rd_page,
   output logic [SEC_W-1:0]           rd_sec
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [PG_W-1:0]  mem_page [DEPTH];
   logic [SEC_W-1:0] mem_sec  [DEPTH];
   logic [PTR_W-1:0] head_ff, tail_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PG_W-1:0]  rd_page_ff;
   logic [SEC_W-1:0] rd_sec_ff;
   logic             do_push, do_pop;

   // a push onto a full queue is dropped
   assign do_push = ctl.push && (count_ff != FULL_CNT);
   assign do_pop  = ctl.pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset || ctl.flush) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            tail_ff <= (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
         end
         if (do_pop) begin
            head_ff <= (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push && !ctl.flush) begin
         mem_page[tail_ff] <= push_page;
         mem_sec[tail_ff]  <= push_sec;
      end
      rd_page_ff <= mem_page[head_ff];
      rd_sec_ff  <= mem_sec[head_ff];
   end

   assign count   = count_ff;
   assign rd_page = rd_page_ff;
   assign rd_sec  = rd_sec_ff;

endmodule

[hw/rtl/flash_record_store_manager.sv]
`timescale 1ns / 1ps
// top level of the flash record store manager: control sequencer, entry ring, csr
// depends on frsm_pkg, frsm_cell, frsm_fifo
//
// usage: one request beat on req_* (func, signature, size, header fields) gives one
// or more response beats on rsp_*; rsp_last marks the final beat of a request.
// the table is a ring of TABLE_ENTRIES cells that rotates one slot per cycle while it
// searches or updates; a lookup is one full turn and a table update is a second turn.
// read: one lookup. scan: no turn for an empty or out-of-range page, a lookup and an
// update for a record header (the lookup only when its generation is older). write:
// a lookup and an update; when the free queue is empty, each managed sector without a
// live entry is erased and its pages queued. erase-all queues every managed page.
// one request is in work at a time; req_ready is high only while the sequencer idles.
// responses sit in an output register; a stalled receiver holds the sequencer, and a
// new request may be taken while the final response still waits.
// reset (synchronous, active high) empties the table and the free queue, rewinds the
// scan and sets sectors_in_use to 4. csr: register 0 at byte address 0 is
// sectors_in_use, 5 bits; the user must see that it is written only while the block
// is idle; the block itself leaves this unenforced.

module flash_record_store_manager
   import frsm_pkg::*;
#(
   parameter int MAX_SECTORS      = 16,
   parameter int PAGES_PER_SECTOR = 16,
   parameter int TABLE_ENTRIES    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_signature,
   input  logic [7:0]  req_size,
   input  logic [31:0] req_header_magic,
   input  logic [31:0] req_generation,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [7:0]  rsp_page_index,
   output logic [31:0] rsp_record_signature,
   output logic [7:0]  rsp_record_size,
   output logic [31:0] rsp_record_generation,
   output logic [3:0]  rsp_sector_index,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int FIFO_DEPTH = MAX_SECTORS * PAGES_PER_SECTOR;
   localparam int PAGE_W = $clog2(FIFO_DEPTH + 1);
   localparam int PG_W   = $clog2(FIFO_DEPTH);
   localparam int SEC_W  = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
   localparam int NS_W   = $clog2(MAX_SECTORS + 1);
   localparam int PIS_W  = $clog2(PAGES_PER_SECTOR);
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [PIS_W-1:0] LAST_PIS = PIS_W'(PAGES_PER_SECTOR - 1);
   localparam logic [PAGE_W-1:0] PPS_STEP = PAGE_W'(PAGES_PER_SECTOR);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_SEARCH, ST_DECIDE, ST_UPDATE, ST_EMIT,
      ST_GC_SEC, ST_GC_PUSH, ST_GC_END, ST_POP_WAIT, ST_POP, ST_FILL
   } state_type;

   // configuration
   logic [4:0]        sectors_ff;
   logic [NS_W-1:0]   nsec;
   logic [PAGE_W-1:0] page_total;

   always_comb begin
      if (sectors_ff == 5'd0) begin
         nsec = NS_W'(1);
      end else if (32'(sectors_ff) > 32'(MAX_SECTORS)) begin
         nsec = NS_W'(MAX_SECTORS);
      end else begin
         nsec = NS_W'(sectors_ff);
      end
      page_total = PAGE_W'(32'(nsec) * 32'(PAGES_PER_SECTOR));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sectors_ff <= 5'd4;
      end else if (psel && penable && pwrite && paddr[2] == REG_SECTORS) begin
         sectors_ff <= pwdata[4:0];
      end
   end

   assign prdata = (paddr[2] == REG_SECTORS) ? {27'd0, sectors_ff} : 32'd0;
   assign pready = 1'b1;

   // sequencer registers
   state_type         state_ff, next_ff;
   logic [1:0]        func_ff;
   logic [31:0]       sig_ff, magic_ff, gen_ff;
   logic [7:0]        size_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              found_ff, has_empty_ff, ins_done_ff, match_mode_ff;
   logic [PG_W-1:0]   found_page_ff;
   logic [7:0]        found_size_ff;
   logic [31:0]       found_gen_ff;
   logic [MAX_SECTORS-1:0] live_ff;
   logic [PG_W-1:0]   new_page_ff;
   logic [SEC_W-1:0]  new_sec_ff;
   logic [31:0]       new_gen_ff;
   logic [PAGE_W-1:0] scan_page_ff;
   logic [NS_W-1:0]   scan_sec_ff;
   logic [PIS_W-1:0]  scan_pis_ff;
   logic [NS_W-1:0]   gc_sec_ff;
   logic [PAGE_W-1:0] gc_base_ff;
   logic [PIS_W-1:0]  pis_ff;
   logic [PAGE_W-1:0] fill_page_ff;
   logic [NS_W-1:0]   fill_sec_ff;
   res_type           pend_ff, out_ff;
   logic              out_valid_ff;

   // ring wiring
   logic              cv    [TABLE_ENTRIES];
   logic [31:0]       csig  [TABLE_ENTRIES];
   logic [PG_W-1:0]   cpage [TABLE_ENTRIES];
   logic [SEC_W-1:0]  csec  [TABLE_ENTRIES];
   logic [7:0]        csize [TABLE_ENTRIES];
   logic [31:0]       cgen  [TABLE_ENTRIES];
   logic              fb_valid;
   logic [31:0]       fb_sig;
   logic [PG_W-1:0]   fb_page;
   logic [SEC_W-1:0]  fb_sec;
   logic [7:0]        fb_size;
   logic [31:0]       fb_gen;
   logic              ring_shift, ring_clear;
   logic              tail_v, tail_hit, upd_hit;

   assign tail_v     = cv[TABLE_ENTRIES-1];
   assign tail_hit   = tail_v && (csig[TABLE_ENTRIES-1] == sig_ff);
   assign upd_hit    = match_mode_ff ? tail_hit : (!tail_v && !ins_done_ff);
   assign ring_shift = (state_ff == ST_SEARCH) || (state_ff == ST_UPDATE);
   assign ring_clear = (state_ff == ST_DISPATCH) && (func_ff == FUNC_ERASE);

   always_comb begin
      fb_valid = tail_v;
      fb_sig   = csig[TABLE_ENTRIES-1];
      fb_page  = cpage[TABLE_ENTRIES-1];
      fb_sec   = csec[TABLE_ENTRIES-1];
      fb_size  = csize[TABLE_ENTRIES-1];
      fb_gen   = cgen[TABLE_ENTRIES-1];
      if (state_ff == ST_UPDATE && upd_hit) begin
         fb_valid = 1'b1;
         fb_sig   = sig_ff;
         fb_page  = new_page_ff;
         fb_sec   = new_sec_ff;
         fb_size  = size_ff;
         fb_gen   = new_gen_ff;
      end
   end

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      if (k == 0) begin : g_head
         frsm_cell #(.PG_W(PG_W), .SEC_W(SEC_W)) u_cell (
            .clock(clock), .reset(reset), .clear(ring_clear), .shift(ring_shift),
            .in_valid(fb_valid), .in_sig(fb_sig), .in_page(fb_page),
            .in_sec(fb_sec), .in_size(fb_size), .in_gen(fb_gen),
            .out_valid(cv[k]), .out_sig(csig[k]), .out_page(cpage[k]),
            .out_sec(csec[k]), .out_size(csize[k]), .out_gen(cgen[k])
         );
      end else begin : g_body
         frsm_cell #(.PG_W(PG_W), .SEC_W(SEC_W)) u_cell (
            .clock(clock), .reset(reset), .clear(ring_clear), .shift(ring_shift),
            .in_valid(cv[k-1]), .in_sig(csig[k-1]), .in_page(cpage[k-1]),
            .in_sec(csec[k-1]), .in_size(csize[k-1]), .in_gen(cgen[k-1]),
            .out_valid(cv[k]), .out_sig(csig[k]), .out_page(cpage[k]),
            .out_sec(csec[k]), .out_size(csize[k]), .out_gen(cgen[k])
         );
      end
   end

   // free queue
   fifo_ctl_type     fctl;
   logic [PG_W-1:0]  push_page;
   logic [SEC_W-1:0] push_sec;
   logic [CNT_W-1:0] free_count;
   logic [PG_W-1:0]  rd_page;
   logic [SEC_W-1:0] rd_sec;
   logic             disp_scan_free;

   assign disp_scan_free = (state_ff == ST_DISPATCH) && (func_ff == FUNC_SCAN)
                           && (scan_page_ff < page_total) && (magic_ff != REC_MAGIC);

   always_comb begin
      fctl.flush = ring_clear;
      fctl.pop   = (state_ff == ST_POP);
      fctl.push  = disp_scan_free || (state_ff == ST_GC_PUSH) || (state_ff == ST_FILL);
      push_page  = scan_page_ff[PG_W-1:0];
      push_sec   = scan_sec_ff[SEC_W-1:0];
      if (state_ff == ST_GC_PUSH) begin
         push_page = PG_W'(gc_base_ff + PAGE_W'(pis_ff));
         push_sec  = gc_sec_ff[SEC_W-1:0];
      end else if (state_ff == ST_FILL) begin
         push_page = fill_page_ff[PG_W-1:0];
         push_sec  = fill_sec_ff[SEC_W-1:0];
      end
   end

   frsm_fifo #(.DEPTH(FIFO_DEPTH), .PG_W(PG_W), .SEC_W(SEC_W)) u_fifo (
      .clock(clock), .reset(reset), .ctl(fctl),
      .push_page(push_page), .push_sec(push_sec),
      .count(free_count), .rd_page(rd_page), .rd_sec(rd_sec)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_ff      <= ST_IDLE;
         out_valid_ff <= 1'b0;
         scan_page_ff <= '0;
         scan_sec_ff  <= '0;
         scan_pis_ff  <= '0;
      end else begin
         // in ST_EMIT the output register is reloaded or held below
         if (out_valid_ff && rsp_ready && state_ff != ST_EMIT) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff  <= req_func;
                  sig_ff   <= req_signature;
                  size_ff  <= req_size;
                  magic_ff <= req_header_magic;
                  gen_ff   <= req_generation;
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               idx_ff       <= '0;
               found_ff     <= 1'b0;
               has_empty_ff <= 1'b0;
               live_ff      <= '0;
               ins_done_ff  <= 1'b0;
               next_ff      <= ST_IDLE;
               unique case (func_ff)
                  FUNC_SCAN: begin
                     if (scan_page_ff >= page_total) begin
                        pend_ff  <= mk_res(KIND_SCAN_END, '0, '0, '0, '0, '0, 1'b1);
                        state_ff <= ST_EMIT;
                     end else begin
                        new_page_ff  <= scan_page_ff[PG_W-1:0];
                        new_sec_ff   <= scan_sec_ff[SEC_W-1:0];
                        scan_page_ff <= scan_page_ff + 1'b1;
                        scan_pis_ff  <= (scan_pis_ff == LAST_PIS) ? '0 : scan_pis_ff + 1'b1;
                        if (scan_pis_ff == LAST_PIS) begin
                           scan_sec_ff <= scan_sec_ff + 1'b1;
                        end
                        if (magic_ff != REC_MAGIC) begin
                           pend_ff  <= mk_res(KIND_SCAN_ACK, 32'(scan_page_ff), '0, '0,
                                              '0, '0, 1'b1);
                           state_ff <= ST_EMIT;
                        end else begin
                           state_ff <= ST_SEARCH;
                        end
                     end
                  end
                  FUNC_READ: begin
                     state_ff <= ST_SEARCH;
                  end
                  FUNC_WRITE: begin
                     if (size_ff == 8'd0 || size_ff > MAX_PAYLOAD) begin
                        pend_ff  <= mk_res(KIND_BAD_SIZE, '0, '0, '0, '0, '0, 1'b1);
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_SEARCH;
                     end
                  end
                  default: begin
                     // erase all: table and queue cleared this cycle, refill follows
                     fill_page_ff <= '0;
                     fill_sec_ff  <= '0;
                     pis_ff       <= '0;
                     state_ff     <= ST_FILL;
                  end
               endcase
            end
            ST_SEARCH: begin
               if (tail_hit) begin
                  found_ff      <= 1'b1;
                  found_page_ff <= cpage[TABLE_ENTRIES-1];
                  found_size_ff <= csize[TABLE_ENTRIES-1];
                  found_gen_ff  <= cgen[TABLE_ENTRIES-1];
               end
               if (!tail_v) begin
                  has_empty_ff <= 1'b1;
               end
               // sector holds a live entry only inside the managed area
               if (tail_v && (32'(csec[TABLE_ENTRIES-1]) < 32'(nsec))) begin
                  live_ff[csec[TABLE_ENTRIES-1]] <= 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               idx_ff        <= '0;
               match_mode_ff <= found_ff;
               unique case (func_ff)
                  FUNC_READ: begin
                     if (found_ff) begin
                        pend_ff <= mk_res(KIND_READ_HIT, 32'(found_page_ff), sig_ff,
                                          found_size_ff, found_gen_ff, '0, 1'b1);
                     end else begin
                        pend_ff <= mk_res(KIND_READ_MISS, '0, sig_ff, '0, '0, '0, 1'b1);
                     end
                     state_ff <= ST_EMIT;
                  end
                  FUNC_SCAN: begin
                     new_gen_ff <= gen_ff;
                     if (!found_ff && !has_empty_ff) begin
                        pend_ff  <= mk_res(KIND_TABLE_FULL, 32'(new_page_ff), '0, '0, '0,
                                           '0, 1'b1);
                        state_ff <= ST_EMIT;
                     end else begin
                        pend_ff <= mk_res(KIND_SCAN_ACK, 32'(new_page_ff), sig_ff, size_ff,
                                          gen_ff, '0, 1'b1);
                        // older generation of a known record leaves the table alone
                        state_ff <= (found_ff && gen_ff < found_gen_ff) ? ST_EMIT : ST_UPDATE;
                     end
                  end
                  default: begin
                     if (!found_ff && !has_empty_ff) begin
                        pend_ff  <= mk_res(KIND_TABLE_FULL, '0, '0, '0, '0, '0, 1'b1);
                        state_ff <= ST_EMIT;
                     end else if (free_count == '0) begin
                        gc_sec_ff  <= '0;
                        gc_base_ff <= '0;
                        state_ff   <= ST_GC_SEC;
                     end else begin
                        state_ff <= ST_POP_WAIT;
                     end
                  end
               endcase
            end
            ST_GC_SEC: begin
               if (gc_sec_ff == nsec) begin
                  state_ff <= ST_GC_END;
               end else if (live_ff[gc_sec_ff[SEC_W-1:0]]) begin
                  gc_sec_ff  <= gc_sec_ff + 1'b1;
                  gc_base_ff <= gc_base_ff + PPS_STEP;
               end else begin
                  pend_ff  <= mk_res(KIND_ERASE_SEC, 32'(gc_base_ff), '0, '0, '0,
                                     32'(gc_sec_ff), 1'b0);
                  pis_ff   <= '0;
                  next_ff  <= ST_GC_PUSH;
                  state_ff <= ST_EMIT;
               end
            end
            ST_GC_PUSH: begin
               pis_ff <= pis_ff + 1'b1;
               if (pis_ff == LAST_PIS) begin
                  gc_sec_ff  <= gc_sec_ff + 1'b1;
                  gc_base_ff <= gc_base_ff + PPS_STEP;
                  state_ff   <= ST_GC_SEC;
               end
            end
            ST_GC_END: begin
               if (free_count == '0) begin
                  pend_ff  <= mk_res(KIND_NO_SPACE, '0, '0, '0, '0, '0, 1'b1);
                  next_ff  <= ST_IDLE;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_POP_WAIT;
               end
            end
            ST_POP_WAIT: begin
               // queue head read lands in the read register this cycle
               state_ff <= ST_POP;
            end
            ST_POP: begin
               new_page_ff <= rd_page;
               new_sec_ff  <= rd_sec;
               new_gen_ff  <= found_ff ? found_gen_ff + 32'd1 : 32'd0;
               pend_ff     <= mk_res(KIND_PROGRAM, 32'(rd_page), sig_ff, size_ff,
                                     found_ff ? found_gen_ff + 32'd1 : 32'd0, '0, 1'b1);
               next_ff     <= ST_IDLE;
               idx_ff      <= '0;
               state_ff    <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (upd_hit) begin
                  ins_done_ff <= 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_FILL: begin
               fill_page_ff <= fill_page_ff + 1'b1;
               pis_ff       <= (pis_ff == LAST_PIS) ? '0 : pis_ff + 1'b1;
               if (pis_ff == LAST_PIS) begin
                  fill_sec_ff <= fill_sec_ff + 1'b1;
               end
               if (fill_page_ff == page_total - 1'b1) begin
                  scan_page_ff <= page_total;
                  scan_sec_ff  <= nsec;
                  scan_pis_ff  <= '0;
                  pend_ff      <= mk_res(KIND_ERASED_ALL, '0, '0, '0, '0, '0, 1'b1);
                  next_ff      <= ST_IDLE;
                  state_ff     <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!out_valid_ff || rsp_ready) begin
                  out_ff       <= pend_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= next_ff;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign rsp_valid             = out_valid_ff;
   assign rsp_kind              = out_ff.kind;
   assign rsp_page_index        = out_ff.page;
   assign rsp_record_signature  = out_ff.sig;
   assign rsp_record_size       = out_ff.size;
   assign rsp_record_generation = out_ff.gen;
   assign rsp_sector_index      = out_ff.sector;
   assign rsp_last              = out_ff.last;

endmodule
